>>> hw/rtl/wrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared codes and controller/datapath interface types for the water ripple
// pixel displacement block.
// ----------------------------------------------------------------------------
package wrp_pkg;

   // map size limits, fixed by the 6-bit coordinate fields
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_PROC = 2'd1;
   localparam logic [1:0] OP_END  = 2'd2;
   localparam logic [1:0] OP_CLR  = 2'd3;

   localparam logic [2:0] CSR_MAP_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_MAP_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_NBR_DIST   = 3'd2;
   localparam logic [2:0] CSR_DAMP_SHIFT = 3'd3;
   localparam logic [2:0] CSR_SEED_SHIFT = 3'd4;

   // previous-map neighbour select
   localparam logic [1:0] NBR_RIGHT = 2'd0;
   localparam logic [1:0] NBR_LEFT  = 2'd1;
   localparam logic [1:0] NBR_DOWN  = 2'd2;
   localparam logic [1:0] NBR_UP    = 2'd3;

   // current-map address select
   localparam logic [1:0] CUR_HERE  = 2'd0;
   localparam logic [1:0] CUR_RIGHT = 2'd1;
   localparam logic [1:0] CUR_DOWN  = 2'd2;
   localparam logic [1:0] CUR_SEED  = 2'd3;

   typedef struct packed {
      logic       latch_item;
      logic       frame_wr;
      logic       frame_rd;
      logic       frame_disp;
      logic       prev_rd;
      logic [1:0] prev_sel;
      logic       cur_rd;
      logic       cur_wr;
      logic [1:0] cur_sel;
      logic       cur_wd_seed;
      logic       clr_start;
      logic       clr_wr;
      logic       toggle_sel;
      logic       sum_load;
      logic       sum_add;
      logic       wave0_load;
      logic       wave_load;
      logic       xo_load;
      logic       yo_load;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       in_range;
      logic       interior;
      logic       quiet;
      logic       cur_zero;
      logic       clr_last;
   } status_type;

endpackage
`default_nettype wire

>>> hw/rtl/water_ripple_pixel_displace_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// water_ripple_pixel_displace_top
// Two-map water ripple that displaces the pixels of one stored frame.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req_* and are taken on a clock edge where start is high
//   and busy is low. Opcodes: load pixel, process pixel, end frame, clear.
//   Only a process item inside the configured size gives a result: one
//   cycle of rsp_valid with out pixel, column and row. The receiver cannot
//   stall; each result is shown for exactly one cycle.
//   Each item holds busy high until its steps are done, so no new item is
//   taken before then; the result strobe is registered from the step that
//   emits it. The full process sequence is set by the single-port wave
//   banks: four previous-map reads, then a read, a write and two more
//   reads of the current map, then the displaced frame read.
//   Clear walks every map cell after decode, then makes one seed write.
//   After reset the same sweep zeroes both banks (no seed), and busy stays
//   high for the whole sweep; csr writes are taken at any time but belong
//   only to idle periods.
// ----------------------------------------------------------------------------
module water_ripple_pixel_displace_top #(
   parameter int WAVE_BITS  = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_opcode,
   input  wire  [5:0]  req_col,
   input  wire  [5:0]  req_row,
   input  wire  [31:0] req_pixel_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_pixel,
   output logic [5:0]  rsp_out_col,
   output logic [5:0]  rsp_out_row,
   input  wire         csr_we,
   input  wire  [2:0]  csr_addr,
   input  wire  [6:0]  csr_wdata
);
   import wrp_pkg::*;

   cmd_type    cmd;
   status_type stat;

   wrp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   wrp_datapath #(
      .WAVE_BITS  (WAVE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_opcode    (req_opcode),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_pixel_in  (req_pixel_in),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row)
   );

endmodule
`default_nettype wire

>>> hw/rtl/wrp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrp_datapath
// Frame store, two wave banks, configuration registers and wave arithmetic.
// ----------------------------------------------------------------------------
module wrp_datapath #(
   parameter int WAVE_BITS  = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_we,
   input  wire  [2:0]           csr_addr,
   input  wire  [6:0]           csr_wdata,
   input  wire  [1:0]           req_opcode,
   input  wire  [5:0]           req_col,
   input  wire  [5:0]           req_row,
   input  wire  [31:0]          req_pixel_in,
   input  wrp_pkg::cmd_type     cmd,
   output wrp_pkg::status_type  stat,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_out_pixel,
   output logic [5:0]           rsp_out_col,
   output logic [5:0]           rsp_out_row
);
   import wrp_pkg::*;

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = WAVE_BITS + 2;

   // configuration
   logic [6:0] mw_ff, mh_ff;
   logic [3:0] nd_ff;
   logic [4:0] ds_ff, ss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mw_ff <= 7'd64;
         mh_ff <= 7'd64;
         nd_ff <= 4'd1;
         ds_ff <= 5'd16;
         ss_ff <= 5'd1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAP_WIDTH:  mw_ff <= csr_wdata;
            CSR_MAP_HEIGHT: mh_ff <= csr_wdata;
            CSR_NBR_DIST:   nd_ff <= csr_wdata[3:0];
            CSR_DAMP_SHIFT: ds_ff <= csr_wdata[4:0];
            CSR_SEED_SHIFT: ss_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   logic [6:0] ew, eh;
   always_comb begin
      if (mw_ff < 7'd2) ew = 7'd2;
      else if (32'(mw_ff) > MAX_WIDTH) ew = 7'(MAX_WIDTH);
      else ew = mw_ff;
      if (mh_ff < 7'd2) eh = 7'd2;
      else if (32'(mh_ff) > MAX_HEIGHT) eh = 7'(MAX_HEIGHT);
      else eh = mh_ff;
   end

   // latched item
   logic [1:0]  op_ff;
   logic [5:0]  col_ff, row_ff;
   logic [31:0] pix_in_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         op_ff     <= req_opcode;
         col_ff    <= req_col;
         row_ff    <= req_row;
         pix_in_ff <= req_pixel_in;
      end
   end

   function automatic logic [AW-1:0] cell_addr(input logic [6:0] c, input logic [6:0] r);
      cell_addr = AW'(32'(r) * MAX_WIDTH + 32'(c));
   endfunction

   logic [6:0] c7, r7;
   assign c7 = {1'b0, col_ff};
   assign r7 = {1'b0, row_ff};

   logic [AW-1:0] here_a, right_a, left_a, down_a, up_a, seed_a, disp_a;
   logic [6:0]    xo_ff, yo_ff;
   assign here_a  = cell_addr(c7, r7);
   assign right_a = cell_addr(c7 + 7'(nd_ff), r7);
   assign left_a  = cell_addr(c7 - 7'(nd_ff), r7);
   assign down_a  = cell_addr(c7, r7 + 7'(nd_ff));
   assign up_a    = cell_addr(c7, r7 - 7'(nd_ff));
   assign seed_a  = cell_addr({1'b0, ew[6:1]}, {1'b0, eh[6:1]});
   assign disp_a  = cell_addr(xo_ff, yo_ff);

   // clear sweep counter
   logic [AW-1:0] clr_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) clr_cnt_ff <= '0;
      else if (cmd.clr_wr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
   end

   logic sel_ff;
   always_ff @(posedge clock) begin
      if (reset) sel_ff <= 1'b0;
      else if (cmd.toggle_sel) sel_ff <= ~sel_ff;
   end

   // seed value
   logic [6:0]           len;
   logic [WAVE_BITS-1:0] seed_val;
   assign len      = (ew > eh) ? ew : eh;
   assign seed_val = WAVE_BITS'(len) << ss_ff;

   logic [WAVE_BITS-1:0] wave_ff, wave0_ff, sum_ff;
   logic [AW-1:0]        cur_addr, prev_addr;
   logic [WAVE_BITS-1:0] cur_wd;

   always_comb begin
      case (cmd.cur_sel)
         CUR_HERE:  cur_addr = here_a;
         CUR_RIGHT: cur_addr = right_a;
         CUR_DOWN:  cur_addr = down_a;
         default:   cur_addr = seed_a;
      endcase
      case (cmd.prev_sel)
         NBR_RIGHT: prev_addr = right_a;
         NBR_LEFT:  prev_addr = left_a;
         NBR_DOWN:  prev_addr = down_a;
         default:   prev_addr = up_a;
      endcase
   end
   assign cur_wd = cmd.cur_wd_seed ? seed_val : wave_ff;

   // wave banks: route current/previous roles by bank select
   logic [WAVE_BITS-1:0] bank_a_mem [CELLS];
   logic [WAVE_BITS-1:0] bank_b_mem [CELLS];
   logic [WAVE_BITS-1:0] rd_a_ff, rd_b_ff;
   logic                 en_a, we_a, en_b, we_b;
   logic [AW-1:0]        addr_a, addr_b;
   logic [WAVE_BITS-1:0] wd_a, wd_b;

   always_comb begin
      en_a   = cmd.clr_wr | (sel_ff ? cmd.prev_rd : (cmd.cur_rd | cmd.cur_wr));
      we_a   = cmd.clr_wr | (~sel_ff & cmd.cur_wr);
      addr_a = cmd.clr_wr ? clr_cnt_ff : (sel_ff ? prev_addr : cur_addr);
      wd_a   = cmd.clr_wr ? '0 : cur_wd;
      en_b   = cmd.clr_wr | (sel_ff ? (cmd.cur_rd | cmd.cur_wr) : cmd.prev_rd);
      we_b   = cmd.clr_wr | (sel_ff & cmd.cur_wr);
      addr_b = cmd.clr_wr ? clr_cnt_ff : (sel_ff ? cur_addr : prev_addr);
      wd_b   = cmd.clr_wr ? '0 : cur_wd;
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         if (we_a) bank_a_mem[addr_a] <= wd_a;
         else rd_a_ff <= bank_a_mem[addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         if (we_b) bank_b_mem[addr_b] <= wd_b;
         else rd_b_ff <= bank_b_mem[addr_b];
      end
   end

   logic [WAVE_BITS-1:0] cur_rd, prev_rd;
   assign cur_rd  = sel_ff ? rd_b_ff : rd_a_ff;
   assign prev_rd = sel_ff ? rd_a_ff : rd_b_ff;

   // frame store
   logic [31:0]   frame_mem [CELLS];
   logic [31:0]   frame_rd_ff;
   logic [AW-1:0] frame_addr;
   assign frame_addr = cmd.frame_disp ? disp_a : here_a;

   always_ff @(posedge clock) begin
      if (cmd.frame_wr) frame_mem[frame_addr] <= pix_in_ff;
      else if (cmd.frame_rd) frame_rd_ff <= frame_mem[frame_addr];
   end

   // wave arithmetic
   logic signed [WAVE_BITS-1:0] wave0_nx, wave_nx;
   assign wave0_nx = ($signed(sum_ff) >>> 1) - $signed(cur_rd);
   assign wave_nx  = $signed(wave0_ff) - ($signed(wave0_ff) >>> ds_ff);

   always_ff @(posedge clock) begin
      if (cmd.sum_load) sum_ff <= prev_rd;
      else if (cmd.sum_add) sum_ff <= sum_ff + prev_rd;
      if (cmd.wave0_load) wave0_ff <= wave0_nx;
      if (cmd.wave_load) wave_ff <= wave_nx;
   end

   function automatic logic [6:0] clamp_coord(input logic signed [XW-1:0] v,
                                              input logic [6:0] hi);
      if (v < 0) clamp_coord = 7'd0;
      else if (v > $signed(XW'(hi))) clamp_coord = hi;
      else clamp_coord = v[6:0];
   endfunction

   logic signed [XW-1:0] disp_v;
   assign disp_v = XW'($signed({1'b0, (cmd.yo_load ? row_ff : col_ff)}))
                 + XW'($signed(cur_rd)) - XW'($signed(wave_ff));

   always_ff @(posedge clock) begin
      if (cmd.xo_load) xo_ff <= clamp_coord(disp_v, ew - 7'd1);
      if (cmd.yo_load) yo_ff <= clamp_coord(disp_v, eh - 7'd1);
   end

   // status
   logic [7:0] c8, r8, d8;
   assign c8 = {2'b00, col_ff};
   assign r8 = {2'b00, row_ff};
   assign d8 = {4'd0, nd_ff};

   always_comb begin
      stat.opcode   = op_ff;
      stat.in_range = (c7 < ew) && (r7 < eh);
      stat.interior = (c8 >= d8) && (c8 + d8 + 8'd1 < {1'b0, ew})
                   && (r8 >= d8) && (r8 + d8 + 8'd1 < {1'b0, eh});
      stat.quiet    = (sum_ff == '0) && (cur_rd == '0);
      stat.cur_zero = (cur_rd == '0);
      stat.clr_last = (32'(clr_cnt_ff) == CELLS - 1);
   end

   // result register
   logic        valid_ff;
   logic [31:0] opix_ff;
   logic [5:0]  ocol_ff, orow_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= cmd.emit;
      if (cmd.emit) begin
         opix_ff <= frame_rd_ff;
         ocol_ff <= col_ff;
         orow_ff <= row_ff;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_pixel = opix_ff;
   assign rsp_out_col   = ocol_ff;
   assign rsp_out_row   = orow_ff;

endmodule
`default_nettype wire

>>> hw/rtl/wrp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrp_ctrl
// Sequencer that steps each item through the memory accesses of the datapath.
// ----------------------------------------------------------------------------
module wrp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wrp_pkg::status_type  stat,
   output wrp_pkg::cmd_type     cmd
);
   import wrp_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CLR   = 5'd1;
   localparam logic [4:0] S_SEED  = 5'd2;
   localparam logic [4:0] S_DEC   = 5'd3;
   localparam logic [4:0] S_EFRD  = 5'd4;
   localparam logic [4:0] S_EFCHK = 5'd5;
   localparam logic [4:0] S_P1    = 5'd6;
   localparam logic [4:0] S_P2    = 5'd7;
   localparam logic [4:0] S_P3    = 5'd8;
   localparam logic [4:0] S_P4    = 5'd9;
   localparam logic [4:0] S_P5    = 5'd10;
   localparam logic [4:0] S_P6    = 5'd11;
   localparam logic [4:0] S_P7    = 5'd12;
   localparam logic [4:0] S_P8    = 5'd13;
   localparam logic [4:0] S_P9    = 5'd14;
   localparam logic [4:0] S_P10   = 5'd15;
   localparam logic [4:0] S_P11   = 5'd16;
   localparam logic [4:0] S_P12   = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       seed_ff, seed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         seed_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      seed_in  = seed_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_item = 1'b1;
               state_in = S_DEC;
            end
         end
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = seed_ff ? S_SEED : S_IDLE;
         end
         S_SEED: begin
            cmd.cur_wr      = 1'b1;
            cmd.cur_sel     = CUR_SEED;
            cmd.cur_wd_seed = 1'b1;
            seed_in  = 1'b0;
            state_in = S_IDLE;
         end
         S_DEC: begin
            case (stat.opcode)
               OP_END: begin
                  cmd.toggle_sel = 1'b1;
                  state_in = S_EFRD;
               end
               OP_CLR: begin
                  cmd.clr_start = 1'b1;
                  seed_in  = 1'b1;
                  state_in = S_CLR;
               end
               OP_LOAD: begin
                  cmd.frame_wr = stat.in_range;
                  state_in = S_IDLE;
               end
               default: begin
                  if (stat.in_range) begin
                     cmd.frame_rd = 1'b1;
                     cmd.prev_rd  = 1'b1;
                     cmd.prev_sel = NBR_RIGHT;
                     cmd.cur_rd   = 1'b1;
                     cmd.cur_sel  = CUR_HERE;
                     state_in = S_P1;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_EFRD: begin
            cmd.cur_rd  = 1'b1;
            cmd.cur_sel = CUR_SEED;
            state_in = S_EFCHK;
         end
         S_EFCHK: begin
            // reseed only where the new current map is flat at the centre
            cmd.cur_wr      = stat.cur_zero;
            cmd.cur_sel     = CUR_SEED;
            cmd.cur_wd_seed = 1'b1;
            state_in = S_IDLE;
         end
         S_P1: begin
            cmd.sum_load = 1'b1;
            if (!stat.interior) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.prev_rd  = 1'b1;
               cmd.prev_sel = NBR_LEFT;
               state_in = S_P2;
            end
         end
         S_P2: begin
            cmd.sum_add  = 1'b1;
            cmd.prev_rd  = 1'b1;
            cmd.prev_sel = NBR_DOWN;
            state_in = S_P3;
         end
         S_P3: begin
            cmd.sum_add  = 1'b1;
            cmd.prev_rd  = 1'b1;
            cmd.prev_sel = NBR_UP;
            state_in = S_P4;
         end
         S_P4: begin
            cmd.sum_add = 1'b1;
            state_in = S_P5;
         end
         S_P5: begin
            if (stat.quiet) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.wave0_load = 1'b1;
               state_in = S_P6;
            end
         end
         S_P6: begin
            cmd.wave_load = 1'b1;
            state_in = S_P7;
         end
         S_P7: begin
            // store before the neighbour reads: a zero distance reads it back
            cmd.cur_wr  = 1'b1;
            cmd.cur_sel = CUR_HERE;
            state_in = S_P8;
         end
         S_P8: begin
            cmd.cur_rd  = 1'b1;
            cmd.cur_sel = CUR_RIGHT;
            state_in = S_P9;
         end
         S_P9: begin
            cmd.cur_rd  = 1'b1;
            cmd.cur_sel = CUR_DOWN;
            cmd.xo_load = 1'b1;
            state_in = S_P10;
         end
         S_P10: begin
            cmd.yo_load = 1'b1;
            state_in = S_P11;
         end
         S_P11: begin
            cmd.frame_rd   = 1'b1;
            cmd.frame_disp = 1'b1;
            state_in = S_P12;
         end
         S_P12: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DEC))
      else $error("accepted item did not reach decode");

   a_emit_single: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit)
      else $error("result emitted on consecutive cycles");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> (cmd.clr_wr && busy && !cmd.emit))
      else $error("clear sweep not writing or not busy");

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the water ripple pixel displacement block: a
// directed table, then randomized ripple frames under several map settings,
// with every result compared to an in-bench ripple predictor or to the table.
// ----------------------------------------------------------------------------
module tb;
   import wrp_pkg::*;

   localparam int CELLS      = 4096;
   localparam int FILL_CELLS = 1024;
   localparam int WD_LIMIT   = 20000;
   localparam int NPHASE     = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_LOAD;
   logic [5:0]  req_col = '0;
   logic [5:0]  req_row = '0;
   logic [31:0] req_pixel_in = '0;
   logic        rsp_valid;
   logic [31:0] rsp_out_pixel;
   logic [5:0]  rsp_out_col;
   logic [5:0]  rsp_out_row;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = CSR_MAP_WIDTH;
   logic [6:0]  csr_wdata = '0;

   water_ripple_pixel_displace_top u_top (.*);

   always #2 clock = ~clock;

   typedef struct {
      logic [31:0] pixel;
      logic [5:0]  col;
      logic [5:0]  row;
   } pixel_rsp_t;

   typedef struct {
      logic [1:0]  op;
      logic [5:0]  col;
      logic [5:0]  row;
      logic [31:0] pix;
      bit          typed;
      logic [31:0] want;
   } dir_row_t;

   // ripple state mirrored from the block
   logic [31:0] frame_m [CELLS];
   logic [31:0] wave_m [2][CELLS];
   bit          bank_sel;
   int          cfg_w, cfg_h, cfg_dist, cfg_damp, cfg_seed;

   pixel_rsp_t  pending_px[$];
   int          mismatches, results_seen, items_sent, wd_count;
   bit          typed_flag;
   logic [31:0] typed_pix;

   function automatic int cell_idx(int c, int r);
      return (r * 64 + c) % CELLS;
   endfunction

   function automatic int eff_w();
      return cfg_w < 2 ? 2 : (cfg_w > 64 ? 64 : cfg_w);
   endfunction

   function automatic int eff_h();
      return cfg_h < 2 ? 2 : (cfg_h > 64 ? 64 : cfg_h);
   endfunction

   function automatic logic signed [31:0] sar(logic signed [31:0] v, int s);
      return v >>> (s >= 32 ? 31 : s);
   endfunction

   function automatic longint clamp_coord(longint v, longint hi);
      return v < 0 ? 0 : (v > hi ? hi : v);
   endfunction

   task automatic seed_centre(bit only_if_zero);
      int w, h, i, len;
      w = eff_w();
      h = eff_h();
      len = w > h ? w : h;
      i = cell_idx(w >> 1, h >> 1);
      if (!(only_if_zero && wave_m[bank_sel][i] != 0))
         wave_m[bank_sel][i] = 32'(len) << (cfg_seed & 31);
   endtask

   // advance the mirrored state by one item, queue the pixel it answers with
   task automatic ripple_predict(logic [1:0] op, int c, int r, logic [31:0] px);
      int w, h, d, here;
      bit cur, prv;
      logic signed [31:0] nsum, nowv, wv;
      longint xo, yo;
      logic [31:0] pix;
      w = eff_w();
      h = eff_h();
      d = cfg_dist;
      if (op == OP_END) begin
         bank_sel = ~bank_sel;
         seed_centre(1);
         return;
      end
      if (op == OP_CLR) begin
         for (int i = 0; i < CELLS; i++) begin
            wave_m[0][i] = '0;
            wave_m[1][i] = '0;
         end
         seed_centre(0);
         return;
      end
      if (c >= w || r >= h) return;
      here = cell_idx(c, r);
      if (op == OP_LOAD) begin
         frame_m[here] = px;
         return;
      end
      pix = frame_m[here];
      if (c >= d && c + d + 1 < w && r >= d && r + d + 1 < h) begin
         cur = bank_sel;
         prv = ~bank_sel;
         nsum = wave_m[prv][cell_idx(c + d, r)] + wave_m[prv][cell_idx(c - d, r)]
              + wave_m[prv][cell_idx(c, r + d)] + wave_m[prv][cell_idx(c, r - d)];
         nowv = wave_m[cur][here];
         if (nsum != 0 || nowv != 0) begin
            wv = sar(nsum, 1) - nowv;
            wv = wv - sar(wv, cfg_damp);
            wave_m[cur][here] = wv;
            xo = longint'(c) + longint'($signed(wave_m[cur][cell_idx(c + d, r)]))
               - longint'(wv);
            yo = longint'(r) + longint'($signed(wave_m[cur][cell_idx(c, r + d)]))
               - longint'(wv);
            xo = clamp_coord(xo, w - 1);
            yo = clamp_coord(yo, h - 1);
            pix = frame_m[cell_idx(int'(xo), int'(yo))];
         end
      end
      pending_px.push_back('{typed_flag ? typed_pix : pix, 6'(c), 6'(r)});
   endtask

   task automatic send_item(logic [1:0] op, int c, int r, logic [31:0] px, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_col      <= 6'(c);
      req_row      <= 6'(r);
      req_pixel_in <= px;
      do @(posedge clock); while (busy);
      ripple_predict(op, c, r, px);
      items_sent++;
   endtask

   task automatic drain_and_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_px.size() != 0 || busy) @(posedge clock);
      // clear or end frame may still be in progress with nothing expected
      repeat (20) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic csr_write(logic [2:0] addr, int val);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= 7'(val);
      @(posedge clock);
      case (addr)
         CSR_MAP_WIDTH:  cfg_w    = val & 'h7F;
         CSR_MAP_HEIGHT: cfg_h    = val & 'h7F;
         CSR_NBR_DIST:   cfg_dist = val & 'hF;
         CSR_DAMP_SHIFT: cfg_damp = val & 'h1F;
         CSR_SEED_SHIFT: cfg_seed = val & 'h1F;
         default: ;
      endcase
   endtask

   // one random item, mostly process items, often near the ripple centre
   task automatic random_item();
      int sel, c, r, w, h;
      w = eff_w();
      h = eff_h();
      sel = $urandom_range(0, 99);
      c = $urandom_range(0, w - 1);
      r = $urandom_range(0, h - 1);
      if ($urandom_range(0, 1)) begin
         c = (w >> 1) + $urandom_range(0, 6) - 3;
         r = (h >> 1) + $urandom_range(0, 6) - 3;
         c = c < 0 ? 0 : (c >= w ? w - 1 : c);
         r = r < 0 ? 0 : (r >= h ? h - 1 : r);
      end
      if ($urandom_range(0, 9) == 0) begin
         c = $urandom_range(0, 63);
         r = $urandom_range(0, 63);
      end
      if (sel < 72)      send_item(OP_PROC, c, r, $urandom, $urandom_range(0, 5));
      else if (sel < 88) send_item(OP_LOAD, c, r, $urandom, $urandom_range(0, 5));
      else if (sel < 98) send_item(OP_END, c, r, $urandom, $urandom_range(0, 5));
      else               send_item(OP_CLR, c, r, $urandom, $urandom_range(0, 5));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         pixel_rsp_t e;
         results_seen++;
         if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result pixel %h col %0d row %0d",
                        rsp_out_pixel, rsp_out_col, rsp_out_row);
         end else begin
            e = pending_px.pop_front();
            if (e.pixel !== rsp_out_pixel || e.col !== rsp_out_col
                || e.row !== rsp_out_row) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want %h (%0d,%0d) got %h (%0d,%0d)",
                           e.pixel, e.col, e.row, rsp_out_pixel, rsp_out_col, rsp_out_row);
            end
         end
      end
   end

   // stall detector
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) wd_count <= 0;
      else wd_count <= wd_count + 1;
      if (wd_count >= WD_LIMIT) begin
         $display("timeout: no progress for %0d cycles", WD_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   dir_row_t dir_tab[$] = '{
      '{OP_LOAD, 0,  0,  32'hA5A5_A5A5, 0, 0},
      '{OP_LOAD, 63, 63, 32'hFFFF_FFFF, 0, 0},
      '{OP_LOAD, 5,  5,  32'h0000_0000, 0, 0},
      '{OP_LOAD, 1,  1,  32'h5A5A_5A5A, 0, 0},
      '{OP_LOAD, 62, 1,  32'h1234_5678, 0, 0},
      '{OP_PROC, 0,  0,  32'h0,         1, 32'hA5A5_A5A5},
      '{OP_PROC, 63, 63, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF},
      '{OP_PROC, 5,  5,  32'h0,         1, 32'h0000_0000},
      '{OP_PROC, 1,  1,  32'h0,         1, 32'h5A5A_5A5A},
      '{OP_PROC, 62, 1,  32'h0,         1, 32'h1234_5678},
      '{OP_END,  0,  0,  32'h0,         0, 0},
      '{OP_PROC, 5,  5,  32'h0,         1, 32'h0000_0000},
      '{OP_CLR,  63, 63, 32'hFFFF_FFFF, 0, 0},
      '{OP_PROC, 63, 63, 32'h0,         1, 32'hFFFF_FFFF},
      '{OP_END,  0,  0,  32'h0,         0, 0}
   };

   // width, height, distance, damping, seed; extremes and out-of-range sizes
   // heights stay within the 16 loaded rows
   int phase_cfg [NPHASE][5] = '{
      '{64, 16, 1, 16, 1},
      '{2, 2, 0, 0, 0},
      '{127, 0, 15, 31, 16},
      '{16, 12, 2, 3, 31},
      '{33, 16, 0, 1, 5},
      '{8, 9, 1, 8, 2}
   };

   initial begin
      cfg_w = 64; cfg_h = 64; cfg_dist = 1; cfg_damp = 16; cfg_seed = 1;
      bank_sel = 0;
      for (int i = 0; i < CELLS; i++) begin
         frame_m[i] = '0;
         wave_m[0][i] = '0;
         wave_m[1][i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[k]) begin
         typed_flag = dir_tab[k].typed;
         typed_pix  = dir_tab[k].want;
         send_item(dir_tab[k].op, dir_tab[k].col, dir_tab[k].row, dir_tab[k].pix,
                   $urandom_range(0, 5));
      end
      typed_flag = 0;

      // fill the top 16 rows so no process item reads an unloaded pixel
      for (int i = 0; i < FILL_CELLS; i++)
         send_item(OP_LOAD, i % 64, i / 64, $urandom, (i % 16 == 0) ? $urandom_range(0, 5) : 0);

      for (int p = 0; p < NPHASE; p++) begin
         drain_and_idle();
         csr_write(CSR_MAP_WIDTH,  phase_cfg[p][0]);
         csr_write(CSR_MAP_HEIGHT, phase_cfg[p][1]);
         csr_write(CSR_NBR_DIST,   phase_cfg[p][2]);
         csr_write(CSR_DAMP_SHIFT, phase_cfg[p][3]);
         csr_write(CSR_SEED_SHIFT, phase_cfg[p][4]);
         csr_we <= 1'b0;
         send_item(OP_CLR, 0, 0, $urandom, 0);
         for (int n = 0; n < 160; n++) begin
            // runs with no idle at all
            if (n % 50 < 10) send_item(OP_PROC, eff_w() >> 1, eff_h() >> 1, $urandom, 0);
            else random_item();
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_px.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d items over %0d map settings, %0d pixel results checked",
               items_sent, NPHASE, results_seen);
      if (mismatches == 0 && pending_px.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_px.size());
         $display("status: fail");
      end
      $finish;
   end
endmodule
